### src/s2d_pkg.sv
// Shared constants, types and helper functions for the space-to-depth
// address generator. No dependencies; every other file uses it.
package s2d_pkg;

	// Index and data sizing
	localparam int INDEX_BITS = 24;
	localparam int DATA_BITS  = 32;
	localparam int MAX_STRIDE = 8;

	// Fixed port field widths
	localparam int DATA_W    = 32;
	localparam int DEST_W    = 24;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;

	// Configuration field widths
	localparam int DIM_W = 11;
	localparam int CH_W  = 13;
	localparam int STR_W = 4;
	localparam int BAT_W = 9;

	// Derived-size arithmetic widths
	localparam int STRIDE_MAX_W = $clog2(MAX_STRIDE + 1);
	localparam int MUL_B_W      = DIM_W + STRIDE_MAX_W;
	localparam int SAT_W        = (INDEX_BITS + 1 > MUL_B_W) ? INDEX_BITS + 1 : MUL_B_W;
	localparam int PROD_W       = SAT_W + MUL_B_W;

	localparam logic [SAT_W-1:0] LIMIT   = SAT_W'(64'd1 << INDEX_BITS);
	localparam logic [SAT_W-1:0] SAT_CAP = LIMIT + SAT_W'(1);

	localparam logic [DATA_W-1:0] DATA_MASK = (DATA_BITS >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << DATA_BITS) - 64'd1);

	// Walk counters: five mixed-radix digits plus the image counter
	localparam int NUM_DIGITS = 5;
	localparam int DIG_W      = 12;
	localparam int IMG_W      = 8;

	// Cycles the derived-size chain needs after a register write
	localparam int SETTLE   = 4;
	localparam int SETTLE_W = $clog2(SETTLE + 1);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUT_WIDTH   = 3'd0,
		REG_OUT_HEIGHT  = 3'd1,
		REG_IN_CHANNELS = 3'd2,
		REG_STRIDE      = 3'd3,
		REG_BATCH_COUNT = 3'd4,
		REG_DIRECTION   = 3'd5
	} reg_idx_t;

	// Walk geometry handed from the size unit to the walk counters
	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIG_W-1:0]      lim_m1;
		logic [NUM_DIGITS-1:0][INDEX_BITS-1:0] step;
		logic [IMG_W-1:0]                      bc_m1;
		logic [INDEX_BITS-1:0]                 per_image;
		logic                                  err;
		logic                                  busy;
		logic                                  clear;
	} geom_t;

	// Address terms of the current element
	typedef struct packed {
		logic [NUM_DIGITS-1:0][INDEX_BITS-1:0] term;
		logic [INDEX_BITS-1:0]                 base;
		logic                                  last;
		logic                                  err;
	} walk_t;

	// Clamp a register into 1..hi, zero counts as one
	function automatic logic [CH_W-1:0] clamp_reg(input logic [CH_W-1:0] v,
			input logic [CH_W-1:0] hi);
		logic [CH_W-1:0] r;
		if (v == '0) begin
			r = CH_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Product that saturates just above the index space
	function automatic logic [SAT_W-1:0] mul_sat(input logic [SAT_W-1:0] a,
			input logic [MUL_B_W-1:0] b);
		logic [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		if (p > PROD_W'(LIMIT)) begin
			return SAT_CAP;
		end
		return p[SAT_W-1:0];
	endfunction

endpackage

### src/s2d_in_if.sv
// Input channel: valid/ready handshake carrying one tensor element.
// Depends on s2d_pkg.
interface s2d_in_if;
	logic                         valid;
	logic                         ready;
	logic [s2d_pkg::DATA_W-1:0]   data_word;

	modport source(output valid, output data_word, input ready);
	modport sink(input valid, input data_word, output ready);
endinterface

### src/s2d_out_if.sv
// Output channel: valid/ready handshake carrying an element and its address.
// Depends on s2d_pkg.
interface s2d_out_if;
	logic                         valid;
	logic                         ready;
	logic [s2d_pkg::DATA_W-1:0]   out_word;
	logic [s2d_pkg::DEST_W-1:0]   dest_index;
	logic                         last_element;
	logic                         range_error;

	modport source(output valid, output out_word, output dest_index,
		output last_element, output range_error, input ready);
	modport sink(input valid, input out_word, input dest_index,
		input last_element, input range_error, output ready);
endinterface

### src/s2d_geom.sv
// Configuration registers and the registered multiplier chain that derives
// walk limits, address steps and the range check. Depends on s2d_pkg.
module s2d_geom (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [s2d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [s2d_pkg::CFG_W-1:0]       cfg_wdata,
	output s2d_pkg::geom_t                  geom
);

	logic [s2d_pkg::DIM_W-1:0]  ow_q, oh_q;
	logic [s2d_pkg::CH_W-1:0]   ic_q;
	logic [s2d_pkg::STR_W-1:0]  str_q;
	logic [s2d_pkg::BAT_W-1:0]  bc_q;
	logic                       dir_q;
	logic                       clear;
	logic [s2d_pkg::SETTLE_W-1:0] settle_q;

	// Clamped sizes
	logic [s2d_pkg::DIM_W-1:0]        ow_c, oh_c;
	logic [s2d_pkg::CH_W-1:0]         ic_c;
	logic [s2d_pkg::STRIDE_MAX_W-1:0] s_c;
	logic [s2d_pkg::BAT_W-1:0]        bc_c;

	// Derived-size pipeline
	logic [s2d_pkg::DIM_W-1:0]        ow_s1, oh_s1;
	logic [s2d_pkg::CH_W-1:0]         ic_s1;
	logic [s2d_pkg::STRIDE_MAX_W-1:0] s_s1;
	logic [s2d_pkg::BAT_W-1:0]        bc_s1;
	logic [s2d_pkg::MUL_B_W-1:0]      fw_s1, fh_s1;
	logic [s2d_pkg::SAT_W-1:0]        p_s1;
	logic [s2d_pkg::SAT_W-1:0]        f_s2, fws_s2, q_s2;
	logic [s2d_pkg::SAT_W-1:0]        pimg_s3, qs_s3;
	logic                             err_s4;

	logic [s2d_pkg::DIG_W-1:0] ow_m1, oh_m1, ic_m1, s_m1;

	// Register write decode
	always_comb begin
		case (cfg_index)
			s2d_pkg::REG_OUT_WIDTH,
			s2d_pkg::REG_OUT_HEIGHT,
			s2d_pkg::REG_IN_CHANNELS,
			s2d_pkg::REG_STRIDE,
			s2d_pkg::REG_BATCH_COUNT,
			s2d_pkg::REG_DIRECTION: clear = cfg_we;
			default: clear = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q  <= s2d_pkg::DIM_W'(1);
			oh_q  <= s2d_pkg::DIM_W'(1);
			ic_q  <= s2d_pkg::CH_W'(1);
			str_q <= s2d_pkg::STR_W'(1);
			bc_q  <= s2d_pkg::BAT_W'(1);
			dir_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				s2d_pkg::REG_OUT_WIDTH:   ow_q  <= cfg_wdata[s2d_pkg::DIM_W-1:0];
				s2d_pkg::REG_OUT_HEIGHT:  oh_q  <= cfg_wdata[s2d_pkg::DIM_W-1:0];
				s2d_pkg::REG_IN_CHANNELS: ic_q  <= cfg_wdata[s2d_pkg::CH_W-1:0];
				s2d_pkg::REG_STRIDE:      str_q <= cfg_wdata[s2d_pkg::STR_W-1:0];
				s2d_pkg::REG_BATCH_COUNT: bc_q  <= cfg_wdata[s2d_pkg::BAT_W-1:0];
				s2d_pkg::REG_DIRECTION:   dir_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Settle counter: sizes are not usable until the chain has refilled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= s2d_pkg::SETTLE_W'(s2d_pkg::SETTLE);
		end else if (clear) begin
			settle_q <= s2d_pkg::SETTLE_W'(s2d_pkg::SETTLE);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - s2d_pkg::SETTLE_W'(1);
		end
	end

	// Saturate registers into their ranges
	always_comb begin
		ow_c = s2d_pkg::DIM_W'(s2d_pkg::clamp_reg(s2d_pkg::CH_W'(ow_q), s2d_pkg::CH_W'(1024)));
		oh_c = s2d_pkg::DIM_W'(s2d_pkg::clamp_reg(s2d_pkg::CH_W'(oh_q), s2d_pkg::CH_W'(1024)));
		ic_c = s2d_pkg::clamp_reg(ic_q, s2d_pkg::CH_W'(4096));
		s_c  = s2d_pkg::STRIDE_MAX_W'(s2d_pkg::clamp_reg(s2d_pkg::CH_W'(str_q),
			s2d_pkg::CH_W'(s2d_pkg::MAX_STRIDE)));
		bc_c = s2d_pkg::BAT_W'(s2d_pkg::clamp_reg(s2d_pkg::CH_W'(bc_q), s2d_pkg::CH_W'(256)));
	end

	// Multiplier chain, one product level per stage
	always_ff @(posedge clk) begin
		ow_s1 <= ow_c;
		oh_s1 <= oh_c;
		ic_s1 <= ic_c;
		s_s1  <= s_c;
		bc_s1 <= bc_c;
		fw_s1 <= s2d_pkg::MUL_B_W'(ow_c) * s2d_pkg::MUL_B_W'(s_c);
		fh_s1 <= s2d_pkg::MUL_B_W'(oh_c) * s2d_pkg::MUL_B_W'(s_c);
		p_s1  <= s2d_pkg::mul_sat(s2d_pkg::SAT_W'(ow_c), s2d_pkg::MUL_B_W'(oh_c));

		f_s2   <= s2d_pkg::mul_sat(s2d_pkg::SAT_W'(fw_s1), fh_s1);
		fws_s2 <= s2d_pkg::mul_sat(s2d_pkg::SAT_W'(fw_s1), s2d_pkg::MUL_B_W'(s_s1));
		q_s2   <= s2d_pkg::mul_sat(p_s1, s2d_pkg::MUL_B_W'(ic_s1));

		pimg_s3 <= s2d_pkg::mul_sat(f_s2, s2d_pkg::MUL_B_W'(ic_s1));
		qs_s3   <= s2d_pkg::mul_sat(q_s2, s2d_pkg::MUL_B_W'(s_s1));

		err_s4 <= s2d_pkg::mul_sat(pimg_s3, s2d_pkg::MUL_B_W'(bc_s1)) > s2d_pkg::LIMIT;
	end

	// Digit limits and steps per direction; digit 0 is the fastest
	always_comb begin
		ow_m1 = s2d_pkg::DIG_W'(ow_s1) - s2d_pkg::DIG_W'(1);
		oh_m1 = s2d_pkg::DIG_W'(oh_s1) - s2d_pkg::DIG_W'(1);
		ic_m1 = s2d_pkg::DIG_W'(ic_s1) - s2d_pkg::DIG_W'(1);
		s_m1  = s2d_pkg::DIG_W'(s_s1) - s2d_pkg::DIG_W'(1);

		if (dir_q) begin
			// column, row, channel, phase x, phase y
			geom.lim_m1[0] = ow_m1;
			geom.lim_m1[1] = oh_m1;
			geom.lim_m1[2] = ic_m1;
			geom.lim_m1[3] = s_m1;
			geom.lim_m1[4] = s_m1;
			geom.step[0]   = s2d_pkg::INDEX_BITS'(s_s1);
			geom.step[1]   = fws_s2[s2d_pkg::INDEX_BITS-1:0];
			geom.step[2]   = f_s2[s2d_pkg::INDEX_BITS-1:0];
			geom.step[3]   = s2d_pkg::INDEX_BITS'(1);
			geom.step[4]   = s2d_pkg::INDEX_BITS'(fw_s1);
		end else begin
			// column phase, column block, row phase, row block, channel
			geom.lim_m1[0] = s_m1;
			geom.lim_m1[1] = ow_m1;
			geom.lim_m1[2] = s_m1;
			geom.lim_m1[3] = oh_m1;
			geom.lim_m1[4] = ic_m1;
			geom.step[0]   = q_s2[s2d_pkg::INDEX_BITS-1:0];
			geom.step[1]   = s2d_pkg::INDEX_BITS'(1);
			geom.step[2]   = qs_s3[s2d_pkg::INDEX_BITS-1:0];
			geom.step[3]   = s2d_pkg::INDEX_BITS'(ow_s1);
			geom.step[4]   = p_s1[s2d_pkg::INDEX_BITS-1:0];
		end
		geom.bc_m1     = s2d_pkg::IMG_W'(bc_s1 - s2d_pkg::BAT_W'(1));
		geom.per_image = pimg_s3[s2d_pkg::INDEX_BITS-1:0];
		geom.err       = err_s4;
		geom.busy      = settle_q != '0;
		geom.clear     = clear;
	end

	chk_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> geom.busy)
		else $error("size chain not marked busy after register write");

endmodule

### src/s2d_walk.sv
// Walk counters: five mixed-radix digits with running address terms,
// image counter and image base. Depends on s2d_pkg.
module s2d_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  s2d_pkg::geom_t    geom,
	input  logic              adv,
	output s2d_pkg::walk_t    cur
);

	logic [s2d_pkg::NUM_DIGITS-1:0][s2d_pkg::DIG_W-1:0]      dig_q;
	logic [s2d_pkg::NUM_DIGITS-1:0][s2d_pkg::INDEX_BITS-1:0] term_q;
	logic [s2d_pkg::IMG_W-1:0]                               img_q;
	logic [s2d_pkg::INDEX_BITS-1:0]                          base_q;

	logic [s2d_pkg::NUM_DIGITS-1:0] wrap;
	logic [s2d_pkg::NUM_DIGITS:0]   carry;
	logic                           img_wrap;

	// Carry chain over the digits
	always_comb begin
		carry[0] = 1'b1;
		for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
			wrap[i]      = dig_q[i] == geom.lim_m1[i];
			carry[i + 1] = carry[i] & wrap[i];
		end
		img_wrap = img_q == geom.bc_m1;

		cur.term = term_q;
		cur.base = base_q;
		cur.last = carry[s2d_pkg::NUM_DIGITS] & img_wrap;
		cur.err  = geom.err;
	end

	// Step the walk on each accepted element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q  <= '0;
			term_q <= '0;
			img_q  <= '0;
			base_q <= '0;
		end else if (geom.clear) begin
			dig_q  <= '0;
			term_q <= '0;
			img_q  <= '0;
			base_q <= '0;
		end else if (adv) begin
			for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
				if (carry[i]) begin
					if (wrap[i]) begin
						dig_q[i]  <= '0;
						term_q[i] <= '0;
					end else begin
						dig_q[i]  <= dig_q[i] + s2d_pkg::DIG_W'(1);
						term_q[i] <= term_q[i] + geom.step[i];
					end
				end
			end
			if (carry[s2d_pkg::NUM_DIGITS]) begin
				if (img_wrap) begin
					img_q  <= '0;
					base_q <= '0;
				end else begin
					img_q  <= img_q + s2d_pkg::IMG_W'(1);
					base_q <= base_q + geom.per_image;
				end
			end
		end
	end

	chk_clear: assert property (@(posedge clk) disable iff (!arst_n)
		geom.clear |=> (dig_q == '0 && term_q == '0 && img_q == '0 && base_q == '0))
		else $error("walk not cleared after register write");

	chk_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(!geom.busy && adv && cur.last) |=>
		(dig_q == '0 && term_q == '0 && img_q == '0 && base_q == '0))
		else $error("walk did not restart after the last element");

endmodule

### src/s2d_sum.sv
// Address adder pipeline with per-stage flow control: captures the element
// and its terms, adds them in two levels, holds the result. Depends on s2d_pkg.
module s2d_sum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [s2d_pkg::DATA_W-1:0]  data_word,
	input  s2d_pkg::walk_t              cur,
	output logic                        can_load,
	s2d_out_if.source                   out_ch
);

	logic v_s1, v_s2, v_s3;
	logic go1, go2, go3;

	logic [s2d_pkg::DATA_W-1:0] data_s1, data_s2, word_s3;
	s2d_pkg::walk_t             cur_s1;

	logic [s2d_pkg::INDEX_BITS-1:0] p0_s2, p1_s2;
	logic                           last_s2, err_s2;
	logic [s2d_pkg::INDEX_BITS-1:0] p0, p1, dest_sum;
	logic [s2d_pkg::DEST_W-1:0]     dest_s3;
	logic                           last_s3, err_s3;

	// Stage advance: a stage loads when empty or when its content moves on
	assign go3      = !v_s3 || out_ch.ready;
	assign go2      = !v_s2 || go3;
	assign go1      = !v_s1 || go2;
	assign can_load = go1;

	// Partial and final sums
	always_comb begin
		p0       = cur_s1.term[0] + cur_s1.term[1] + cur_s1.term[2];
		p1       = cur_s1.term[3] + cur_s1.term[4] + cur_s1.base;
		dest_sum = p0_s2 + p1_s2;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (go1) v_s1 <= load;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= data_word;
			cur_s1  <= cur;
		end
		if (v_s1 && go2) begin
			data_s2 <= data_s1;
			p0_s2   <= p0;
			p1_s2   <= p1;
			last_s2 <= cur_s1.last;
			err_s2  <= cur_s1.err;
		end
		if (v_s2 && go3) begin
			word_s3 <= data_s2 & s2d_pkg::DATA_MASK;
			dest_s3 <= err_s2 ? '0 : s2d_pkg::DEST_W'(dest_sum);
			last_s3 <= last_s2;
			err_s3  <= err_s2;
		end
	end

	assign out_ch.valid        = v_s3;
	assign out_ch.out_word     = word_s3;
	assign out_ch.dest_index   = dest_s3;
	assign out_ch.last_element = last_s3;
	assign out_ch.range_error  = err_s3;

	chk_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !go2) |=> (v_s1 && $stable(data_s1)))
		else $error("first stage lost a stalled element");

endmodule

### src/space_to_depth_reorg_addressing.sv
// Space-to-depth address generator: an element passes the capture, partial-sum
// and result registers of the adder pipeline; one element per cycle sustained
// while the output accepts. After reset or any write to a known register, input
// ready is low while the multiplier chain rebuilds derived sizes. Reset restores
// default registers (all sizes 1, forward direction) and clears the walk counters.
module space_to_depth_reorg_addressing (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [s2d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [s2d_pkg::CFG_W-1:0]       cfg_wdata,
	s2d_in_if.sink                          in_ch,
	s2d_out_if.source                       out_ch
);

	s2d_pkg::geom_t geom;
	s2d_pkg::walk_t cur;
	logic           can_load;
	logic           in_fire;

	assign in_ch.ready = can_load && !geom.busy;
	assign in_fire     = in_ch.valid && in_ch.ready;

	s2d_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.geom      (geom)
	);

	s2d_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.adv    (in_fire),
		.cur    (cur)
	);

	s2d_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.data_word (in_ch.data_word),
		.cur       (cur),
		.can_load  (can_load),
		.out_ch    (out_ch)
	);

	chk_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		geom.busy |-> !in_ch.ready)
		else $error("input accepted while derived sizes settle");

endmodule

### tb/space_to_depth_reorg_addressing_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for space_to_depth_reorg_addressing: directed rows, then
// random register settings and element streams, checked against a local address model.
// Depends on s2d_pkg, s2d_in_if, s2d_out_if and the block itself.
module space_to_depth_reorg_addressing_test;

	localparam int LATENCY     = 3;
	localparam int DRAIN_BOUND = 4000;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_ITEMS = 1850;

	// REG_SPARE_6 and REG_SPARE_7 decode to no register; element rows carry NO_REG, index 0
	localparam logic [s2d_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [s2d_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [s2d_pkg::CFG_IDX_W-1:0] NO_REG      = '0;

	// One element with its placement
	typedef struct packed {
		logic [s2d_pkg::DATA_W-1:0] word;
		logic [s2d_pkg::DEST_W-1:0] dest;
		logic                       last;
		logic                       err;
	} placement_t;

	// Directed row: either a register write or an element, optionally with a typed result
	typedef struct packed {
		logic                          is_write;
		logic [s2d_pkg::CFG_IDX_W-1:0] index;
		logic [s2d_pkg::CFG_W-1:0]     value;
		logic [s2d_pkg::DATA_W-1:0]    word;
		logic                          typed;
		logic [s2d_pkg::DEST_W-1:0]    dest;
		logic                          last;
		logic                          err;
	} vector_row_t;

	localparam vector_row_t DIRECTED [41] = '{
		// defaults: a one-element tensor, every element is the last
		'{1'b0, NO_REG, 13'd0, 32'h0000_0000, 1'b1, 24'd0, 1'b1, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'hFFFF_FFFF, 1'b1, 24'd0, 1'b1, 1'b0},
		// small forward reorg
		'{1'b1, s2d_pkg::REG_STRIDE, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_OUT_WIDTH, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_IN_CHANNELS, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'hA5A5_A5A5, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h5A5A_5A5A, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h0000_FFFF, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'hFFFF_0000, 1'b0, 24'd0, 1'b0, 1'b0},
		// unknown index: ignored, the walk carries on
		'{1'b1, REG_SPARE_6, 13'h1FFF, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h1357_9BDF, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h2468_ACE0, 1'b0, 24'd0, 1'b0, 1'b0},
		// inverse map
		'{1'b1, s2d_pkg::REG_DIRECTION, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h8000_0000, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h0000_0001, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h7FFF_FFFE, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h0F0F_0F0F, 1'b0, 24'd0, 1'b0, 1'b0},
		// zero counts as one, stride above the cap
		'{1'b1, s2d_pkg::REG_OUT_HEIGHT, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_STRIDE, 13'd15, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_BATCH_COUNT, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, REG_SPARE_7, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'hF0F0_F0F0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h3C3C_3C3C, 1'b0, 24'd0, 1'b0, 1'b0},
		// tensor that exactly fills the index space
		'{1'b1, s2d_pkg::REG_DIRECTION, 13'd1, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_STRIDE, 13'd1, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_OUT_WIDTH, 13'd1024, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_OUT_HEIGHT, 13'd1024, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_IN_CHANNELS, 13'd16, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_BATCH_COUNT, 13'd1, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h1111_1111, 1'b1, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h2222_2222, 1'b0, 24'd0, 1'b0, 1'b0},
		// one image more overflows it
		'{1'b1, s2d_pkg::REG_BATCH_COUNT, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h3333_3333, 1'b1, 24'd0, 1'b0, 1'b1},
		// channels, batch count and width beyond their ranges, stride at its cap
		'{1'b1, s2d_pkg::REG_IN_CHANNELS, 13'h1FFF, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_STRIDE, 13'd8, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_BATCH_COUNT, 13'd511, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b1, s2d_pkg::REG_OUT_WIDTH, 13'd2047, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h4444_4444, 1'b1, 24'd0, 1'b0, 1'b1},
		'{1'b1, s2d_pkg::REG_DIRECTION, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
		'{1'b0, NO_REG, 13'd0, 32'h5555_5555, 1'b1, 24'd0, 1'b0, 1'b1},
		'{1'b0, NO_REG, 13'd0, 32'h6666_6666, 1'b0, 24'd0, 1'b0, 1'b0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [s2d_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [s2d_pkg::CFG_W-1:0]     cfg_wdata;

	s2d_in_if  in_ch();
	s2d_out_if out_ch();

	space_to_depth_reorg_addressing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Address model: registers, clamped geometry and walk position
	logic [s2d_pkg::DIM_W-1:0] width_reg, height_reg;
	logic [s2d_pkg::CH_W-1:0]  chan_reg;
	logic [s2d_pkg::STR_W-1:0] stride_reg;
	logic [s2d_pkg::BAT_W-1:0] batch_reg;
	logic                      dir_reg;

	bit [63:0] g_ow, g_oh, g_ic, g_s, g_bc, g_per_image, g_total;
	bit        g_oversize;

	logic [12:0] walk_col, walk_row;
	logic [17:0] walk_chan;
	logic [7:0]  walk_image;
	logic [11:0] walk_group;
	logic [5:0]  walk_phase;
	bit [63:0]   walk_base;

	placement_t placements_due[$];

	int failures = 0;
	int items_sent = 0;
	int directed_items = 0;
	int results_checked = 0;
	int ends_seen = 0;
	int range_flags = 0;
	int settings = 0;
	int cycle_count = 0;
	int stall_left = 0;
	int sink_roll = 0;
	bit sink_calm = 1'b0;
	bit source_calm = 1'b0;

	function automatic bit [63:0] clamp_size(input bit [63:0] v, input bit [63:0] hi);
		if (v == 0) return 64'd1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void refresh_geometry();
		g_ow = clamp_size(64'(width_reg), 1024);
		g_oh = clamp_size(64'(height_reg), 1024);
		g_ic = clamp_size(64'(chan_reg), 4096);
		g_s  = clamp_size(64'(stride_reg), s2d_pkg::MAX_STRIDE);
		g_bc = clamp_size(64'(batch_reg), 256);
		g_per_image = g_ow * g_oh * g_ic * g_s * g_s;
		g_total = g_per_image * g_bc;
		g_oversize = g_total > (64'd1 << s2d_pkg::INDEX_BITS);
	endfunction

	function automatic void clear_walk();
		walk_col = '0;
		walk_row = '0;
		walk_chan = '0;
		walk_image = '0;
		walk_group = '0;
		walk_phase = '0;
		walk_base = '0;
	endfunction

	function automatic void reset_model();
		width_reg = s2d_pkg::DIM_W'(1);
		height_reg = s2d_pkg::DIM_W'(1);
		chan_reg = s2d_pkg::CH_W'(1);
		stride_reg = s2d_pkg::STR_W'(1);
		batch_reg = s2d_pkg::BAT_W'(1);
		dir_reg = 1'b1;
		clear_walk();
		refresh_geometry();
	endfunction

	// A write to a known register restarts the walk
	function automatic void apply_reg_write(input logic [s2d_pkg::CFG_IDX_W-1:0] idx,
			input logic [s2d_pkg::CFG_W-1:0] val);
		bit known;
		known = 1'b1;
		case (idx)
			s2d_pkg::REG_OUT_WIDTH:   width_reg = val[s2d_pkg::DIM_W-1:0];
			s2d_pkg::REG_OUT_HEIGHT:  height_reg = val[s2d_pkg::DIM_W-1:0];
			s2d_pkg::REG_IN_CHANNELS: chan_reg = val[s2d_pkg::CH_W-1:0];
			s2d_pkg::REG_STRIDE:      stride_reg = val[s2d_pkg::STR_W-1:0];
			s2d_pkg::REG_BATCH_COUNT: batch_reg = val[s2d_pkg::BAT_W-1:0];
			s2d_pkg::REG_DIRECTION:   dir_reg = val[0];
			default:                  known = 1'b0;
		endcase
		if (known) begin
			clear_walk();
			refresh_geometry();
		end
	endfunction

	function automatic void next_image();
		walk_base = walk_base + g_per_image;
		if (64'(walk_image) + 1 < g_bc) begin
			walk_image++;
		end else begin
			walk_image = '0;
			walk_base = '0;
		end
	endfunction

	// Destination of the current element, then step the walk
	function automatic placement_t place_element(input logic [s2d_pkg::DATA_W-1:0] word);
		placement_t r;
		bit [63:0] col, row, grp, ph, img, fw, fh, ss, dest;
		bit last;
		col = 64'(walk_col);
		row = 64'(walk_row);
		grp = 64'(walk_group);
		ph  = 64'(walk_phase);
		img = 64'(walk_image);
		fw = g_ow * g_s;
		fh = g_oh * g_s;
		ss = g_s * g_s;
		if (dir_reg) begin
			// source is the reduced tensor: image, channel k, row, column
			dest = walk_base + col * g_s + ph % g_s +
				fw * (row * g_s + ph / g_s + fh * grp);
			last = col == g_ow - 1 && row == g_oh - 1 && grp == g_ic - 1 &&
				ph == ss - 1 && img == g_bc - 1;
			if (col + 1 < g_ow) begin
				walk_col++;
			end else begin
				walk_col = '0;
				if (row + 1 < g_oh) begin
					walk_row++;
				end else begin
					walk_row = '0;
					walk_chan++;
					if (grp + 1 < g_ic) begin
						walk_group++;
					end else begin
						walk_group = '0;
						if (ph + 1 < ss) begin
							walk_phase++;
						end else begin
							walk_phase = '0;
							walk_chan = '0;
							next_image();
						end
					end
				end
			end
		end else begin
			// source is the full tensor: image, channel, row, column
			dest = walk_base + col / g_s + g_ow * (row / g_s + g_oh *
				(((row % g_s) * g_s + col % g_s) * g_ic + grp));
			last = col == fw - 1 && row == fh - 1 && grp == g_ic - 1 && img == g_bc - 1;
			if (col + 1 < fw) begin
				walk_col++;
			end else begin
				walk_col = '0;
				if (row + 1 < fh) begin
					walk_row++;
				end else begin
					walk_row = '0;
					if (grp + 1 < g_ic) begin
						walk_group++;
					end else begin
						walk_group = '0;
						next_image();
					end
				end
			end
		end
		r.word = word & s2d_pkg::DATA_MASK;
		r.dest = g_oversize ? '0 :
			s2d_pkg::DEST_W'(dest & ((64'd1 << s2d_pkg::INDEX_BITS) - 1));
		r.last = last;
		r.err = g_oversize;
		return r;
	endfunction

	// Sender gap: mostly back to back, sometimes short, rarely long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (source_calm || roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mostly small sizes so tensors complete; now and then any bit pattern
	function automatic logic [s2d_pkg::CFG_W-1:0] pick_reg_value(input s2d_pkg::reg_idx_t r);
		if ($urandom_range(0, 9) == 0) begin
			return s2d_pkg::CFG_W'($urandom_range(0, (1 << s2d_pkg::CFG_W) - 1));
		end
		case (r)
			s2d_pkg::REG_OUT_WIDTH:   return s2d_pkg::CFG_W'($urandom_range(1, 4));
			s2d_pkg::REG_OUT_HEIGHT:  return s2d_pkg::CFG_W'($urandom_range(1, 4));
			s2d_pkg::REG_IN_CHANNELS: return s2d_pkg::CFG_W'($urandom_range(1, 3));
			s2d_pkg::REG_STRIDE: begin
				if ($urandom_range(0, 5) == 0) begin
					return s2d_pkg::CFG_W'($urandom_range(4, s2d_pkg::MAX_STRIDE));
				end
				return s2d_pkg::CFG_W'($urandom_range(1, 3));
			end
			s2d_pkg::REG_BATCH_COUNT: return s2d_pkg::CFG_W'($urandom_range(1, 3));
			default:                  return s2d_pkg::CFG_W'($urandom_range(0, 1));
		endcase
	endfunction

	// Called at a falling edge; leaves the write enable high for a following write
	task automatic write_reg(input logic [s2d_pkg::CFG_IDX_W-1:0] idx,
			input logic [s2d_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg_write(idx, val);
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic push_word(input logic [s2d_pkg::DATA_W-1:0] w, input int gap,
			input bit typed, input placement_t typed_result);
		placement_t predicted;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_word <= w;
		do @(posedge clk); while (!in_ch.ready);
		predicted = place_element(w);
		if (typed) predicted = typed_result;
		placements_due.push_back(predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and let every pending result come out
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (placements_due.size() != 0 && waited < DRAIN_BOUND) begin
			@(negedge clk);
			waited++;
		end
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// Result side: random stalls, with calm stretches
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (sink_calm) begin
			out_ch.ready <= 1'b1;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 3) begin
				stall_left = $urandom_range(8, 40);
				out_ch.ready <= 1'b0;
			end else if (sink_roll < 25) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest pending placement
	placement_t due;
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (out_ch.last_element === 1'b1) ends_seen++;
			if (out_ch.range_error === 1'b1) range_flags++;
			if (placements_due.size() == 0) begin
				$error("result with nothing pending: out_word %h dest_index %h",
					out_ch.out_word, out_ch.dest_index);
				failures++;
			end else begin
				due = placements_due.pop_front();
				results_checked++;
				if (out_ch.out_word !== due.word) begin
					$error("out_word: expected %h, got %h", due.word, out_ch.out_word);
					failures++;
				end
				if (out_ch.dest_index !== due.dest) begin
					$error("dest_index: expected %0d, got %0d", due.dest, out_ch.dest_index);
					failures++;
				end
				if (out_ch.last_element !== due.last) begin
					$error("last_element: expected %b, got %b", due.last, out_ch.last_element);
					failures++;
				end
				if (out_ch.range_error !== due.err) begin
					$error("range_error: expected %b, got %b", due.err, out_ch.range_error);
					failures++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				placements_due.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		vector_row_t row;
		bit in_writes;
		int random_sent;
		int count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_word = '0;
		in_writes = 1'b0;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows
		foreach (DIRECTED[n]) begin
			row = DIRECTED[n];
			if (row.is_write) begin
				if (!in_writes) begin
					drain_pipeline();
					in_writes = 1'b1;
					settings++;
				end
				write_reg(row.index, row.value);
			end else begin
				if (in_writes) begin
					cfg_we <= 1'b0;
					in_writes = 1'b0;
				end
				push_word(row.word, 0, row.typed, '{row.word, row.dest, row.last, row.err});
			end
		end
		directed_items = items_sent;

		// Random settings, each followed by a stream of elements
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain_pipeline();
			settings++;
			for (int r = s2d_pkg::REG_OUT_WIDTH; r <= s2d_pkg::REG_DIRECTION; r++) begin
				write_reg(s2d_pkg::CFG_IDX_W'(r), pick_reg_value(s2d_pkg::reg_idx_t'(r)));
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
					s2d_pkg::CFG_W'($urandom_range(0, (1 << s2d_pkg::CFG_W) - 1)));
			end
			cfg_we <= 1'b0;
			source_calm = $urandom_range(0, 3) == 0;
			sink_calm = $urandom_range(0, 3) == 0;
			if (g_total <= 300) begin
				count = int'(g_total) * $urandom_range(1, 2) + $urandom_range(0, 3);
			end else begin
				count = $urandom_range(10, 80);
			end
			repeat (count) begin
				push_word($urandom, pick_gap(), 1'b0, '0);
				random_sent++;
			end
		end

		sink_calm = 1'b0;
		drain_pipeline();
		if (placements_due.size() != 0) begin
			$error("%0d results never arrived", placements_due.size());
			failures++;
		end
		$display("%0d elements (%0d directed) over %0d register settings, %0d results checked",
			items_sent, directed_items, settings, results_checked);
		$display("%0d tensor ends and %0d out-of-range results seen", ends_seen, range_flags);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
